// ===== hw/rtl/blps_pkg.sv =====
// blps_pkg: shared types and constants for the bump light pixel shader
// used by blps_falloff and bump_light_pixel_shader; depends on nothing
package blps_pkg;

   // payload widths fixed by the pixel word
   localparam int PIX_W       = 6;
   localparam int HEIGHT_W    = 8;
   localparam int INT_W       = 5;
   // width of pixel + height - height (range -255 .. 318)
   localparam int SUM_W       = 10;

   // configuration port
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Y = 1'b1;
   localparam logic signed [CSR_DATA_W-1:0] LIGHT_RESET = 8'sd32;

   // min(32768/r, 255) >> 3 equals min(4096/r, 31): the level is the
   // count of k in 1..31 for which r <= 4096/k
   localparam int LEVEL_NUM   = 32768 >> 3;
   localparam int LEVEL_MAX   = 31;

   // control that travels with each word down the pipeline
   typedef struct packed {
      logic valid;
      logic lit;
   } blps_ctl_type;

endpackage

// ===== hw/rtl/blps_falloff.sv =====
// blps_falloff: squared distance and light falloff, three register stages
// depends on blps_pkg
module blps_falloff #(
   parameter int XC_W = 7,
   parameter int YC_W = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  blps_pkg::blps_ctl_type    in_ctl,
   input  logic signed [XC_W-1:0]    in_xc,
   input  logic signed [YC_W-1:0]    in_yc,
   output logic                      out_valid,
   output logic [blps_pkg::INT_W-1:0] out_level
);

   localparam int INT_W   = blps_pkg::INT_W;
   localparam int LVL_N   = blps_pkg::LEVEL_MAX;
   localparam int XSQ_W   = 2 * XC_W;
   localparam int YSQ_W   = 2 * YC_W;
   localparam int R_W     = ((XSQ_W > YSQ_W) ? XSQ_W : YSQ_W) + 1;
   localparam int THR_W   = $clog2(blps_pkg::LEVEL_NUM + 1);
   localparam int CMP_W   = (R_W > THR_W) ? R_W : THR_W;

   // stage a: squares
   logic signed [XSQ_W-1:0]   xw;
   logic signed [YSQ_W-1:0]   yw;
   logic [XSQ_W-1:0]          xsq_in, xsq_ff;
   logic [YSQ_W-1:0]          ysq_in, ysq_ff;
   blps_pkg::blps_ctl_type    ctl_a_ff;

   // stage b: distance against threshold bank
   logic [CMP_W-1:0]          r_sum;
   logic [LVL_N-1:0]          therm_in, therm_ff;
   blps_pkg::blps_ctl_type    ctl_b_ff;

   // stage c: level
   logic [INT_W-1:0]          level_in, level_ff;
   logic                      valid_c_ff;

   // sign-extend and square each offset
   assign xw     = XSQ_W'(in_xc);
   assign yw     = YSQ_W'(in_yc);
   assign xsq_in = $unsigned(xw * xw);
   assign ysq_in = $unsigned(yw * yw);

   // squared distance
   assign r_sum = CMP_W'(xsq_ff) + CMP_W'(ysq_ff);

   // one compare per level step, thresholds fixed at elaboration
   for (genvar gk = 1; gk <= LVL_N; gk++) begin : g_thresh
      localparam int THRESH = blps_pkg::LEVEL_NUM / gk;
      assign therm_in[gk-1] = (r_sum <= CMP_W'(THRESH));
   end

   // count the thermometer bits, dark outside the light square
   always_comb begin
      logic [INT_W-1:0] cnt;
      cnt = '0;
      for (int i = 0; i < LVL_N; i++) begin
         cnt = cnt + INT_W'(therm_ff[i]);
      end
      level_in = ctl_b_ff.lit ? cnt : '0;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff   <= '0;
         ctl_b_ff   <= '0;
         valid_c_ff <= 1'b0;
      end else begin
         ctl_a_ff   <= in_ctl;
         ctl_b_ff   <= ctl_a_ff;
         valid_c_ff <= ctl_b_ff.valid;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      xsq_ff   <= xsq_in;
      ysq_ff   <= ysq_in;
      therm_ff <= therm_in;
      level_ff <= level_in;
   end

   assign out_valid = valid_c_ff;
   assign out_level = level_ff;

endmodule

// ===== hw/rtl/bump_light_pixel_shader.sv =====
// bump_light_pixel_shader: bump-mapped point light, one pixel word per clock
// depends on blps_pkg and blps_falloff
//
// Takes one pixel word per clock whenever start is high and busy is low;
// busy is high only while reset is held. Each word gives one rsp_intensity
// word, marked by rsp_valid for exactly one clock; rsp_valid is carried with
// the word through each register stage. The pipeline never stalls: five
// register stages (displace and clamp, light-square test, squares, distance
// against a bank of 31 fixed thresholds, level count) each move every clock,
// so the rate is one word per clock. The 32768/r falloff is found by
// comparing r with the constants 4096/k instead of dividing. light_x and
// light_y are written through csr_we, csr_index and csr_wdata and should
// change only while no word is in flight.
module bump_light_pixel_shader #(
   parameter int MAP_WIDTH    = 64,
   parameter int MAP_HEIGHT   = 64,
   parameter int LIGHT_SPAN_X = 64,
   parameter int LIGHT_SPAN_Y = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [blps_pkg::PIX_W-1:0]            req_pixel_x,
   input  logic [blps_pkg::PIX_W-1:0]            req_pixel_y,
   input  logic [blps_pkg::HEIGHT_W-1:0]         req_height_left,
   input  logic [blps_pkg::HEIGHT_W-1:0]         req_height_right,
   input  logic [blps_pkg::HEIGHT_W-1:0]         req_height_up,
   input  logic [blps_pkg::HEIGHT_W-1:0]         req_height_down,
   output logic                                  rsp_valid,
   output logic [blps_pkg::INT_W-1:0]            rsp_intensity,
   input  logic                                  csr_we,
   input  logic [blps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [blps_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int SUM_W   = blps_pkg::SUM_W;
   localparam int LT_W    = blps_pkg::CSR_DATA_W;
   localparam int DX_W    = $clog2(MAP_WIDTH);
   localparam int DY_W    = $clog2(MAP_HEIGHT);
   localparam int DFX_W   = ((DX_W > LT_W) ? DX_W : LT_W) + 2;
   localparam int DFY_W   = ((DY_W > LT_W) ? DY_W : LT_W) + 2;
   localparam int XC_W    = $clog2(LIGHT_SPAN_X) + 1;
   localparam int YC_W    = $clog2(LIGHT_SPAN_Y) + 1;
   // light square on each axis is [-SPAN/2, SPAN - SPAN/2)
   localparam int X_LO    = -(LIGHT_SPAN_X / 2);
   localparam int X_HI    = LIGHT_SPAN_X - LIGHT_SPAN_X / 2;
   localparam int Y_LO    = -(LIGHT_SPAN_Y / 2);
   localparam int Y_HI    = LIGHT_SPAN_Y - LIGHT_SPAN_Y / 2;

   // light position registers
   logic signed [LT_W-1:0]    light_x_ff, light_y_ff;

   // stage 1: displaced and clamped point
   logic                      req_take;
   logic signed [SUM_W-1:0]   sum_x, sum_y;
   logic [DX_W-1:0]           dx_in, dx_ff;
   logic [DY_W-1:0]           dy_in, dy_ff;
   logic                      valid1_ff;

   // stage 2: offset from the light and square test
   logic signed [DFX_W-1:0]   dfx;
   logic signed [DFY_W-1:0]   dfy;
   logic signed [XC_W-1:0]    xc_ff;
   logic signed [YC_W-1:0]    yc_ff;
   blps_pkg::blps_ctl_type    ctl2_in, ctl2_ff;

   assign busy     = reset;
   assign req_take = start & ~busy;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= blps_pkg::LIGHT_RESET;
         light_y_ff <= blps_pkg::LIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            blps_pkg::CSR_LIGHT_X: light_x_ff <= $signed(csr_wdata);
            blps_pkg::CSR_LIGHT_Y: light_y_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // displace by the height slopes
   assign sum_x = $signed(SUM_W'(req_pixel_x)) + $signed(SUM_W'(req_height_right))
                - $signed(SUM_W'(req_height_left));
   assign sum_y = $signed(SUM_W'(req_pixel_y)) + $signed(SUM_W'(req_height_down))
                - $signed(SUM_W'(req_height_up));

   // clamp into the map
   always_comb begin
      if (sum_x < 0) begin
         dx_in = '0;
      end else if (int'(sum_x) > MAP_WIDTH - 1) begin
         dx_in = DX_W'(MAP_WIDTH - 1);
      end else begin
         dx_in = DX_W'(sum_x);
      end
      if (sum_y < 0) begin
         dy_in = '0;
      end else if (int'(sum_y) > MAP_HEIGHT - 1) begin
         dy_in = DY_W'(MAP_HEIGHT - 1);
      end else begin
         dy_in = DY_W'(sum_y);
      end
   end

   // offset from the light centre and light square test
   assign dfx = DFX_W'($signed({1'b0, dx_ff})) - DFX_W'(light_x_ff);
   assign dfy = DFY_W'($signed({1'b0, dy_ff})) - DFY_W'(light_y_ff);

   always_comb begin
      ctl2_in.valid = valid1_ff;
      ctl2_in.lit   = (dfx >= DFX_W'(X_LO)) && (dfx < DFX_W'(X_HI))
                   && (dfy >= DFY_W'(Y_LO)) && (dfy < DFY_W'(Y_HI));
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         ctl2_ff   <= '0;
      end else begin
         valid1_ff <= req_take;
         ctl2_ff   <= ctl2_in;
      end
   end

   // data registers; offsets only matter inside the light square
   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      xc_ff <= XC_W'(dfx);
      yc_ff <= YC_W'(dfy);
   end

   // squares, distance and falloff level
   blps_falloff #(
      .XC_W (XC_W),
      .YC_W (YC_W)
   ) u_falloff (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl2_ff),
      .in_xc     (xc_ff),
      .in_yc     (yc_ff),
      .out_valid (rsp_valid),
      .out_level (rsp_intensity)
   );

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for bump_light_pixel_shader
// drives pixel words and light writes, predicts each intensity word or takes a typed level from the table
// depends on blps_pkg and the bump_light_pixel_shader rtl

module tb;

   // widths taken from the package
   localparam int PIX_W      = blps_pkg::PIX_W;
   localparam int HEIGHT_W   = blps_pkg::HEIGHT_W;
   localparam int INT_W      = blps_pkg::INT_W;
   localparam int CSR_IDX_W  = blps_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = blps_pkg::CSR_DATA_W;

   // block parameters as instantiated
   localparam int MAP_W  = 64;
   localparam int MAP_H  = 64;
   localparam int SPAN_X = 64;
   localparam int SPAN_Y = 64;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_WORDS   = 170;
   localparam int MAX_REPORTS   = 20;

   // one row of the directed table: light setting, pixel word, optional typed level
   typedef struct packed {
      logic signed [CSR_DATA_W-1:0] lx;
      logic signed [CSR_DATA_W-1:0] ly;
      logic [PIX_W-1:0]             px;
      logic [PIX_W-1:0]             py;
      logic [HEIGHT_W-1:0]          hl;
      logic [HEIGHT_W-1:0]          hr;
      logic [HEIGHT_W-1:0]          hu;
      logic [HEIGHT_W-1:0]          hd;
      logic                         typed;
      logic [INT_W-1:0]             level;
   } shade_row_type;

   typedef struct packed {
      int unsigned      seq;
      logic [INT_W-1:0] level;
   } shade_exp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [PIX_W-1:0]      req_pixel_x = '0;
   logic [PIX_W-1:0]      req_pixel_y = '0;
   logic [HEIGHT_W-1:0]   req_height_left = '0;
   logic [HEIGHT_W-1:0]   req_height_right = '0;
   logic [HEIGHT_W-1:0]   req_height_up = '0;
   logic [HEIGHT_W-1:0]   req_height_down = '0;
   logic                  rsp_valid;
   logic [INT_W-1:0]      rsp_intensity;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = blps_pkg::CSR_LIGHT_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // testbench copy of the light registers
   logic signed [CSR_DATA_W-1:0] light_x_now = blps_pkg::LIGHT_RESET;
   logic signed [CSR_DATA_W-1:0] light_y_now = blps_pkg::LIGHT_RESET;

   shade_exp_type pending_levels[$];
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   int unsigned lit_words = 0;
   int unsigned light_writes = 0;
   int unsigned fail_count = 0;

   // directed table: centre, map edges, clamps, square edges, light off the map
   shade_row_type shade_table [23] = '{
      '{8'sd32,  8'sd32,  6'd32, 6'd32, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 5'd31},
      '{8'sd32,  8'sd32,  6'd0,  6'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 5'd0},
      '{8'sd32,  8'sd32,  6'd63, 6'd63, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 5'd0},
      '{8'sd32,  8'sd32,  6'd0,  6'd0,  8'd255, 8'd0,   8'd255, 8'd0,   1'b0, 5'd0},
      '{8'sd32,  8'sd32,  6'd63, 6'd63, 8'd0,   8'd255, 8'd0,   8'd255, 1'b0, 5'd0},
      '{8'sd32,  8'sd32,  6'd10, 6'd40, 8'd0,   8'd22,  8'd8,   8'd0,   1'b1, 5'd31},
      '{8'sd32,  8'sd32,  6'd21, 6'd42, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 5'd0},
      '{8'sd32,  8'sd32,  6'd5,  6'd60, 8'd200, 8'd13,  8'd0,   8'd170, 1'b0, 5'd0},
      '{8'sd31,  8'sd31,  6'd63, 6'd20, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 5'd0},
      '{8'sd31,  8'sd31,  6'd20, 6'd63, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 5'd0},
      '{8'sd0,   8'sd0,   6'd0,  6'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 5'd31},
      '{8'sd0,   8'sd0,   6'd31, 6'd31, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 5'd0},
      '{8'sd63,  8'sd63,  6'd63, 6'd63, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 5'd31},
      '{8'sd95,  8'sd95,  6'd63, 6'd63, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 5'd0},
      '{8'sd95,  8'sd95,  6'd62, 6'd63, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 5'd0},
      '{8'sd127, 8'sd127, 6'd63, 6'd63, 8'd0,   8'd255, 8'd0,   8'd255, 1'b1, 5'd0},
      '{-8'sd64, -8'sd64, 6'd0,  6'd0,  8'd255, 8'd0,   8'd255, 8'd0,   1'b1, 5'd0},
      '{-8'sd31, -8'sd31, 6'd0,  6'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 5'd0},
      '{-8'sd32, -8'sd32, 6'd0,  6'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 5'd0},
      '{8'sd127, -8'sd64, 6'd42, 6'd21, 8'd3,   8'd7,   8'd9,   8'd1,   1'b1, 5'd0},
      // most negative code on the write port
      '{8'sh80,  8'sd127, 6'd63, 6'd0,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 5'd0},
      '{8'sd16,  8'sd48,  6'd17, 6'd47, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 5'd0},
      '{8'sd16,  8'sd48,  6'd40, 6'd20, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 5'd0}
   };

   bump_light_pixel_shader #(
      .MAP_WIDTH   (MAP_W),
      .MAP_HEIGHT  (MAP_H),
      .LIGHT_SPAN_X(SPAN_X),
      .LIGHT_SPAN_Y(SPAN_Y)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_height_left (req_height_left),
      .req_height_right(req_height_right),
      .req_height_up   (req_height_up),
      .req_height_down (req_height_down),
      .rsp_valid       (rsp_valid),
      .rsp_intensity   (rsp_intensity),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predicted intensity of one pixel word under a given light
   function automatic logic [INT_W-1:0] shade_level(
      input logic signed [CSR_DATA_W-1:0] lx, ly,
      input logic [PIX_W-1:0] px, py,
      input logic [HEIGHT_W-1:0] hl, hr, hu, hd);
      int bx, by, ox, oy, rsq, ratio;
      bx = int'(px) + int'(hr) - int'(hl);
      by = int'(py) + int'(hd) - int'(hu);
      bx = (bx < 0) ? 0 : (bx > MAP_W - 1) ? MAP_W - 1 : bx;
      by = (by < 0) ? 0 : (by > MAP_H - 1) ? MAP_H - 1 : by;
      ox = bx - int'(lx);
      oy = by - int'(ly);
      // dark outside the light square
      if (ox < -(SPAN_X / 2) || ox >= SPAN_X / 2 || oy < -(SPAN_Y / 2) || oy >= SPAN_Y / 2)
         return '0;
      rsq = ox * ox + oy * oy;
      if (rsq == 0) rsq = 1;
      ratio = 32768 / rsq;
      if (ratio > 255) ratio = 255;
      return INT_W'(ratio >> 3);
   endfunction

   // neighbour height a few steps from a base height
   function automatic logic [HEIGHT_W-1:0] near_height(input int base);
      int v;
      v = base + int'($urandom_range(24)) - 12;
      v = (v < 0) ? 0 : (v > 255) ? 255 : v;
      return HEIGHT_W'(v);
   endfunction

   function automatic logic signed [CSR_DATA_W-1:0] pick_light();
      int v;
      case ($urandom_range(7))
         0: v = -64;
         1: v = 127;
         default: v = int'($urandom_range(191)) - 64;
      endcase
      return v[CSR_DATA_W-1:0];
   endfunction

   // write both light registers once the pipeline has drained
   task automatic set_light(input logic signed [CSR_DATA_W-1:0] lx, ly);
      start <= 1'b0;
      @(posedge clock);
      while (pending_levels.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= blps_pkg::CSR_LIGHT_X;
      csr_wdata <= lx;
      @(posedge clock);
      csr_index <= blps_pkg::CSR_LIGHT_Y;
      csr_wdata <= ly;
      @(posedge clock);
      csr_we <= 1'b0;
      light_x_now = lx;
      light_y_now = ly;
      light_writes++;
   endtask

   // present one pixel word and log its expected level once taken
   task automatic send_word(input logic [PIX_W-1:0] px, py,
                            input logic [HEIGHT_W-1:0] hl, hr, hu, hd,
                            input bit may_idle, input bit typed,
                            input logic [INT_W-1:0] typed_level);
      logic [INT_W-1:0] want;
      while (may_idle && $urandom_range(99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      req_height_left <= hl;
      req_height_right <= hr;
      req_height_up <= hu;
      req_height_down <= hd;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = typed ? typed_level : shade_level(light_x_now, light_y_now, px, py, hl, hr, hu, hd);
      pending_levels.push_back(shade_exp_type'{words_sent, want});
      if (want != '0) lit_words++;
      words_sent++;
   endtask

   // compare each intensity word with the oldest expectation
   always @(posedge clock) begin : check_words
      shade_exp_type want;
      if (!reset && rsp_valid) begin
         if (pending_levels.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected intensity word %0d", $time, rsp_intensity);
         end else begin
            want = pending_levels.pop_front();
            words_checked++;
            if (rsp_intensity !== want.level) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: word %0d intensity expected %0d got %0d",
                           $time, want.seq, want.level, rsp_intensity);
            end
         end
      end
   end

   initial begin : stimulus
      shade_row_type row;
      logic [PIX_W-1:0] px, py;
      logic [HEIGHT_W-1:0] hl, hr, hu, hd;
      int base, rnd_index;
      bit may_idle;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, light rewritten whenever a row asks for a new one
      foreach (shade_table[i]) begin
         row = shade_table[i];
         if (row.lx != light_x_now || row.ly != light_y_now)
            set_light(row.lx, row.ly);
         send_word(row.px, row.py, row.hl, row.hr, row.hu, row.hd, 1'b1,
                   row.typed, row.level);
      end

      // random phases, each under a fresh light setting
      rnd_index = 0;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_light(pick_light(), pick_light());
         for (int w = 0; w < PHASE_WORDS; w++) begin
            case ($urandom_range(9))
               // smooth bump: neighbours close, pixel anywhere
               0, 1, 2, 3, 4, 5: begin
                  px = PIX_W'($urandom_range(63));
                  py = PIX_W'($urandom_range(63));
                  base = int'($urandom_range(255));
                  hl = HEIGHT_W'(base);
                  hr = near_height(base);
                  base = int'($urandom_range(255));
                  hu = HEIGHT_W'(base);
                  hd = near_height(base);
               end
               // pixel near the light centre, flat in x, gentle slope in y
               6, 7: begin
                  base = int'(light_x_now) + int'($urandom_range(6)) - 3;
                  px = PIX_W'((base < 0) ? 0 : (base > 63) ? 63 : base);
                  base = int'(light_y_now) + int'($urandom_range(6)) - 3;
                  py = PIX_W'((base < 0) ? 0 : (base > 63) ? 63 : base);
                  base = int'($urandom_range(255));
                  hl = HEIGHT_W'(base);
                  hr = HEIGHT_W'(base);
                  hu = HEIGHT_W'(base);
                  hd = near_height(base);
               end
               // rough terrain, mostly clamped
               default: begin
                  px = PIX_W'($urandom_range(63));
                  py = PIX_W'($urandom_range(63));
                  hl = HEIGHT_W'($urandom_range(255));
                  hr = HEIGHT_W'($urandom_range(255));
                  hu = HEIGHT_W'($urandom_range(255));
                  hd = HEIGHT_W'($urandom_range(255));
               end
            endcase
            // back-to-back stretch in the middle of the random part
            may_idle = !(rnd_index >= 500 && rnd_index < 800);
            send_word(px, py, hl, hr, hu, hd, may_idle, 1'b0, '0);
            rnd_index++;
         end
      end

      start <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("shaded %0d pixel words (%0d lit) under %0d light writes, %0d words checked",
               words_sent, lit_words, light_writes, words_checked);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("%0d failures", fail_count);
         $display("tb NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("timeout with %0d words outstanding", pending_levels.size());
      $display("tb NOT OK");
      $finish;
   end

endmodule
